@@ hdl/fbf_pkg.sv @@
// Shared types and constants for the framebuffer fill engine.
// No dependencies; every other file of the block imports it.
`timescale 1ns / 1ps

package fbf_pkg;

    localparam int DEF_MAX_WIDTH  = 64;
    localparam int DEF_MAX_HEIGHT = 64;

    localparam int CANVAS_W    = 7;
    localparam int ACTION_W    = 3;
    localparam int POS_W       = 6;
    localparam int SIZE_W      = 7;
    localparam int CHAN_W      = 8;
    localparam int PIXEL_W     = 24;
    localparam int RSQ_W       = 14;
    localparam int COUNT_W     = 13;
    localparam int CFG_INDEX_W = 1;
    localparam int IDX_W       = 14;
    localparam int HALF_W      = 6;
    localparam int HSQ_W       = 12;
    localparam int SQ_W        = 14;
    localparam int DELTA_W     = 8;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [CANVAS_W-1:0] CANVAS_RESET = 7'd64;

    typedef enum logic [ACTION_W-1:0] {
        ACT_CLEAR = 3'd0,
        ACT_RECT  = 3'd1,
        ACT_DISC  = 3'd2,
        ACT_POINT = 3'd3,
        ACT_READ  = 3'd4
    } action_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_WIDTH  = 1'b0,
        CFG_HEIGHT = 1'b1
    } cfg_reg_t;

    typedef enum logic [1:0] {
        KIND_NONE,
        KIND_FILL,
        KIND_READ
    } kind_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DONE
    } back_state_t;

    typedef struct packed {
        kind_t               kind;
        logic                disc;
        logic [PIXEL_W-1:0]  color;
        logic [IDX_W-1:0]    start_idx;
        logic [SIZE_W-1:0]   ncols;
        logic [SIZE_W-1:0]   nrows;
        logic [SIZE_W-1:0]   stride;
        logic [RSQ_W-1:0]    rsq;
        logic [HALF_W-1:0]   half_w;
        logic [HALF_W-1:0]   half_h;
        logic [HSQ_W-1:0]    half_w_sq;
        logic [HSQ_W-1:0]    half_h_sq;
    } cmd_t;

endpackage

@@ hdl/framebuffer_rect_disc_fill_top.sv @@
// Fill engine top level: front end decode, command queue and pixel engine.
// Depends on fbf_pkg, fbf_front, fbf_queue and fbf_back.
`timescale 1ns / 1ps

// Commands run one at a time in the pixel engine, which visits one pixel per cycle
// and writes through the single write port of the frame store. The disc test is
// done on every pixel of the clipped box, and a disc writes only the pixels that
// pass it. Up to two decoded commands wait in the queue, so new commands are
// taken while a long fill runs and while a result waits on the output. The frame
// store is not cleared after reset; read only pixels that were written.
module framebuffer_rect_disc_fill_top #(
    parameter int MAX_WIDTH  = fbf_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = fbf_pkg::DEF_MAX_HEIGHT
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [fbf_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [fbf_pkg::CANVAS_W-1:0]      cfg_data,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [fbf_pkg::ACTION_W-1:0]      action,
    input  logic [fbf_pkg::POS_W-1:0]         x_pos,
    input  logic [fbf_pkg::POS_W-1:0]         y_pos,
    input  logic [fbf_pkg::SIZE_W-1:0]        rect_width,
    input  logic [fbf_pkg::SIZE_W-1:0]        rect_height,
    input  logic [fbf_pkg::CHAN_W-1:0]        red,
    input  logic [fbf_pkg::CHAN_W-1:0]        green,
    input  logic [fbf_pkg::CHAN_W-1:0]        blue,
    input  logic [fbf_pkg::RSQ_W-1:0]         radius_sq,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [fbf_pkg::PIXEL_W-1:0]       read_pixel,
    output logic [fbf_pkg::COUNT_W-1:0]       pixels_written
);
    import fbf_pkg::*;

    cmd_t front_cmd;
    cmd_t queue_cmd;
    logic push;
    logic queue_full;
    logic cmd_valid;
    logic cmd_ready;

    fbf_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .action      (action),
        .x_pos       (x_pos),
        .y_pos       (y_pos),
        .rect_width  (rect_width),
        .rect_height (rect_height),
        .red         (red),
        .green       (green),
        .blue        (blue),
        .radius_sq   (radius_sq),
        .queue_full  (queue_full),
        .push        (push),
        .cmd         (front_cmd)
    );

    fbf_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_cmd  (front_cmd),
        .full      (queue_full),
        .pop       (cmd_valid && cmd_ready),
        .cmd_valid (cmd_valid),
        .pop_cmd   (queue_cmd)
    );

    fbf_back #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd_valid      (cmd_valid),
        .cmd            (queue_cmd),
        .cmd_ready      (cmd_ready),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .read_pixel     (read_pixel),
        .pixels_written (pixels_written)
    );

`ifndef SYNTHESIS
    a_one_cmd_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_valid && cmd_ready) |=> !cmd_ready)
        else $error("engine took a second command while busy");

    a_result_from_busy_engine: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(!cmd_ready))
        else $error("result appeared without a command in the engine");

    a_accepted_cmd_queued: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> cmd_valid)
        else $error("accepted transaction missing from queue");
`endif

endmodule

@@ hdl/fbf_front.sv @@
// Front end: canvas size registers, command decode, clipping and start address.
// Depends on fbf_pkg; feeds fbf_queue.
`timescale 1ns / 1ps

module fbf_front #(
    parameter int MAX_WIDTH  = fbf_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = fbf_pkg::DEF_MAX_HEIGHT
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [fbf_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [fbf_pkg::CANVAS_W-1:0]      cfg_data,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [fbf_pkg::ACTION_W-1:0]      action,
    input  logic [fbf_pkg::POS_W-1:0]         x_pos,
    input  logic [fbf_pkg::POS_W-1:0]         y_pos,
    input  logic [fbf_pkg::SIZE_W-1:0]        rect_width,
    input  logic [fbf_pkg::SIZE_W-1:0]        rect_height,
    input  logic [fbf_pkg::CHAN_W-1:0]        red,
    input  logic [fbf_pkg::CHAN_W-1:0]        green,
    input  logic [fbf_pkg::CHAN_W-1:0]        blue,
    input  logic [fbf_pkg::RSQ_W-1:0]         radius_sq,
    input  logic                              queue_full,
    output logic                              push,
    output fbf_pkg::cmd_t                     cmd
);
    import fbf_pkg::*;

    logic [CANVAS_W-1:0] canvas_width_reg;
    logic [CANVAS_W-1:0] canvas_height_reg;
    logic [CANVAS_W-1:0] act_w;
    logic [CANVAS_W-1:0] act_h;
    logic [CANVAS_W:0]   x_end;
    logic [CANVAS_W:0]   y_end;
    logic [CANVAS_W:0]   x_clip;
    logic [CANVAS_W:0]   y_clip;
    logic [SIZE_W-1:0]   rect_cols;
    logic [SIZE_W-1:0]   rect_rows;
    logic                in_canvas;
    logic [POS_W-1:0]    start_x;
    logic [POS_W-1:0]    start_y;
    logic [COUNT_W-1:0]  row_base;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            canvas_width_reg  <= CANVAS_RESET;
            canvas_height_reg <= CANVAS_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                CFG_WIDTH:  canvas_width_reg  <= cfg_data;
                CFG_HEIGHT: canvas_height_reg <= cfg_data;
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        act_w = (32'(canvas_width_reg) > MAX_WIDTH) ? CANVAS_W'(MAX_WIDTH) : canvas_width_reg;
        act_h = (32'(canvas_height_reg) > MAX_HEIGHT) ? CANVAS_W'(MAX_HEIGHT)
                                                      : canvas_height_reg;

        x_end  = (CANVAS_W+1)'(x_pos) + (CANVAS_W+1)'(rect_width);
        y_end  = (CANVAS_W+1)'(y_pos) + (CANVAS_W+1)'(rect_height);
        x_clip = (x_end > {1'b0, act_w}) ? {1'b0, act_w} : x_end;
        y_clip = (y_end > {1'b0, act_h}) ? {1'b0, act_h} : y_end;
        rect_cols = (x_clip > (CANVAS_W+1)'(x_pos)) ? SIZE_W'(x_clip - (CANVAS_W+1)'(x_pos))
                                                     : '0;
        rect_rows = (y_clip > (CANVAS_W+1)'(y_pos)) ? SIZE_W'(y_clip - (CANVAS_W+1)'(y_pos))
                                                     : '0;
        in_canvas = ({1'b0, x_pos} < act_w) && ({1'b0, y_pos} < act_h);

        cmd           = '0;
        cmd.kind      = KIND_NONE;
        cmd.color     = {red, green, blue};
        cmd.stride    = act_w;
        cmd.rsq       = radius_sq;
        cmd.half_w    = rect_width[SIZE_W-1:1];
        cmd.half_h    = rect_height[SIZE_W-1:1];
        cmd.half_w_sq = HSQ_W'(cmd.half_w) * HSQ_W'(cmd.half_w);
        cmd.half_h_sq = HSQ_W'(cmd.half_h) * HSQ_W'(cmd.half_h);
        start_x       = x_pos;
        start_y       = y_pos;

        unique case (action_t'(action)) inside
            ACT_CLEAR:
            begin
                start_x   = '0;
                start_y   = '0;
                cmd.ncols = act_w;
                cmd.nrows = act_h;
                if ((act_w != '0) && (act_h != '0))
                    cmd.kind = KIND_FILL;
            end
            ACT_RECT, ACT_DISC:
            begin
                cmd.ncols = rect_cols;
                cmd.nrows = rect_rows;
                cmd.disc  = (action_t'(action) == ACT_DISC);
                if ((rect_cols != '0) && (rect_rows != '0))
                    cmd.kind = KIND_FILL;
            end
            ACT_POINT:
            begin
                cmd.ncols = SIZE_W'(1);
                cmd.nrows = SIZE_W'(1);
                if (in_canvas)
                    cmd.kind = KIND_FILL;
            end
            ACT_READ:
            begin
                if (in_canvas)
                    cmd.kind = KIND_READ;
            end
            default: ;
        endcase

        row_base      = COUNT_W'(start_y) * COUNT_W'(act_w);
        cmd.start_idx = IDX_W'(row_base) + IDX_W'(start_x);

        in_ready = !queue_full;
        push     = in_valid && !queue_full;
    end

endmodule

@@ hdl/fbf_queue.sv @@
// Short command queue between the decode front end and the pixel engine.
// Depends on fbf_pkg for the command type and depth.
`timescale 1ns / 1ps

module fbf_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  fbf_pkg::cmd_t push_cmd,
    output logic          full,
    input  logic          pop,
    output logic          cmd_valid,
    output fbf_pkg::cmd_t pop_cmd
);
    import fbf_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

    cmd_t             entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W:0]   count_reg;
    logic [PTR_W:0]   count_next;

    always_comb
    begin
        full       = (count_reg == (PTR_W+1)'(QUEUE_DEPTH));
        cmd_valid  = (count_reg != '0);
        pop_cmd    = entry_reg[rd_ptr_reg];
        count_next = count_reg + (PTR_W+1)'(push) - (PTR_W+1)'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_cmd;
    end

endmodule

@@ hdl/fbf_back.sv @@
// Pixel engine: frame store, rectangle and disc walker, read port, result register.
// Depends on fbf_pkg; takes commands from fbf_queue.
`timescale 1ns / 1ps

module fbf_back #(
    parameter int MAX_WIDTH  = fbf_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = fbf_pkg::DEF_MAX_HEIGHT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cmd_valid,
    input  fbf_pkg::cmd_t                 cmd,
    output logic                          cmd_ready,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [fbf_pkg::PIXEL_W-1:0]   read_pixel,
    output logic [fbf_pkg::COUNT_W-1:0]   pixels_written
);
    import fbf_pkg::*;

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [PIXEL_W-1:0]        mem [DEPTH];

    back_state_t               state_reg;
    back_state_t               state_next;
    cmd_t                      cmd_reg;
    logic [AW-1:0]             addr_reg;
    logic [AW-1:0]             row_addr_reg;
    logic [SIZE_W-1:0]         col_reg;
    logic [SIZE_W-1:0]         row_reg;
    logic signed [DELTA_W-1:0] dx_reg;
    logic signed [DELTA_W-1:0] dy_reg;
    logic [SQ_W-1:0]           dxsq_reg;
    logic [SQ_W-1:0]           dysq_reg;
    logic [COUNT_W-1:0]        count_reg;
    logic [PIXEL_W-1:0]        rdata_reg;
    logic                      is_read_reg;
    logic                      out_valid_reg;
    logic [PIXEL_W-1:0]        out_pixel_reg;
    logic [COUNT_W-1:0]        out_count_reg;

    logic                      pop;
    logic                      hit;
    logic                      wr_en;
    logic                      last_col;
    logic                      last_row;
    logic                      out_free;
    logic                      load_out;
    logic [AW-1:0]             next_row_addr;
    logic [SQ_W-1:0]           dxsq_next;
    logic [SQ_W-1:0]           dysq_next;
    logic signed [DELTA_W-1:0] dx_start;
    logic signed [DELTA_W-1:0] dy_start;
    logic signed [DELTA_W-1:0] dx_row_start;

    always_comb
    begin
        cmd_ready     = (state_reg == ST_IDLE);
        pop           = cmd_valid && cmd_ready;
        hit           = !cmd_reg.disc ||
                        (({1'b0, dxsq_reg} + {1'b0, dysq_reg}) < {1'b0, cmd_reg.rsq});
        wr_en         = (state_reg == ST_RUN) && hit;
        last_col      = (col_reg == cmd_reg.ncols - SIZE_W'(1));
        last_row      = (row_reg == cmd_reg.nrows - SIZE_W'(1));
        out_free      = !out_valid_reg || out_ready;
        load_out      = (state_reg == ST_DONE) && out_free;
        next_row_addr = row_addr_reg + AW'(cmd_reg.stride);
        dxsq_next     = SQ_W'({1'b0, dxsq_reg} + (SQ_W+1)'($signed({dx_reg, 1'b1})));
        dysq_next     = SQ_W'({1'b0, dysq_reg} + (SQ_W+1)'($signed({dy_reg, 1'b1})));
        dx_start      = -$signed({2'b00, cmd.half_w});
        dy_start      = -$signed({2'b00, cmd.half_h});
        dx_row_start  = -$signed({2'b00, cmd_reg.half_w});
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (pop)
                    state_next = (cmd.kind == KIND_FILL) ? ST_RUN : ST_DONE;
            end
            ST_RUN:
            begin
                if (last_col && last_row)
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cmd_reg      <= cmd;
            addr_reg     <= AW'(cmd.start_idx);
            row_addr_reg <= AW'(cmd.start_idx);
            col_reg      <= '0;
            row_reg      <= '0;
            dx_reg       <= dx_start;
            dy_reg       <= dy_start;
            dxsq_reg     <= SQ_W'(cmd.half_w_sq);
            dysq_reg     <= SQ_W'(cmd.half_h_sq);
            count_reg    <= '0;
            is_read_reg  <= (cmd.kind == KIND_READ);
        end
        else if (state_reg == ST_RUN)
        begin
            if (wr_en)
                count_reg <= count_reg + COUNT_W'(1);
            if (last_col)
            begin
                row_addr_reg <= next_row_addr;
                addr_reg     <= next_row_addr;
                col_reg      <= '0;
                row_reg      <= row_reg + SIZE_W'(1);
                dx_reg       <= dx_row_start;
                dxsq_reg     <= SQ_W'(cmd_reg.half_w_sq);
                dy_reg       <= dy_reg + DELTA_W'(1);
                dysq_reg     <= dysq_next;
            end
            else
            begin
                addr_reg <= addr_reg + AW'(1);
                col_reg  <= col_reg + SIZE_W'(1);
                dx_reg   <= dx_reg + DELTA_W'(1);
                dxsq_reg <= dxsq_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[addr_reg] <= cmd_reg.color;
        if (pop && (cmd.kind == KIND_READ))
            rdata_reg <= mem[AW'(cmd.start_idx)];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (load_out)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_pixel_reg <= is_read_reg ? rdata_reg : '0;
            out_count_reg <= count_reg;
        end
    end

    assign out_valid      = out_valid_reg;
    assign read_pixel     = out_pixel_reg;
    assign pixels_written = out_count_reg;

endmodule

@@ verif/framebuffer_rect_disc_fill_top_tb.sv @@
// Self-checking testbench for the framebuffer fill engine: directed and random fill,
// point and read commands with canvas size changes, checked against a pixel-level predictor.
// Depends on fbf_pkg and framebuffer_rect_disc_fill_top.
`timescale 1ns / 1ps

module framebuffer_rect_disc_fill_top_tb;

    import fbf_pkg::*;

    localparam int STORE_DEPTH = DEF_MAX_WIDTH * DEF_MAX_HEIGHT;
    localparam int MAX_SIZE    = DEF_MAX_WIDTH;
    localparam int MAX_RSQ     = (1 << RSQ_W) - 1;
    localparam logic [ACTION_W-1:0] ACT_UNUSED_LO = 3'd5;
    localparam logic [ACTION_W-1:0] ACT_UNUSED_HI = 3'd7;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [POS_W-1:0]    x_pos;
        logic [POS_W-1:0]    y_pos;
        logic [SIZE_W-1:0]   rect_width;
        logic [SIZE_W-1:0]   rect_height;
        logic [CHAN_W-1:0]   red;
        logic [CHAN_W-1:0]   green;
        logic [CHAN_W-1:0]   blue;
        logic [RSQ_W-1:0]    radius_sq;
    } fill_cmd_t;

    typedef struct packed {
        logic [PIXEL_W-1:0] pixel;
        logic [COUNT_W-1:0] count;
    } fill_result_t;

    class fill_scoreboard;
        logic [PIXEL_W-1:0] frame [STORE_DEPTH];
        int unsigned        canvas_w;
        int unsigned        canvas_h;
        fill_result_t       expected_q [$];
        int                 errors;
        int                 checked;
        int                 pixels_total;
        int                 act_count [8];

        function new();
            for (int i = 0; i < STORE_DEPTH; i++)
                frame[i] = '0;
            canvas_w = CANVAS_RESET;
            canvas_h = CANVAS_RESET;
            errors = 0;
            checked = 0;
            pixels_total = 0;
            foreach (act_count[i])
                act_count[i] = 0;
        endfunction

        function void set_canvas(cfg_reg_t idx, logic [CANVAS_W-1:0] val);
            if (idx == CFG_WIDTH)
                canvas_w = val;
            else
                canvas_h = val;
        endfunction

        function int unsigned eff_width();
            return (canvas_w > DEF_MAX_WIDTH) ? DEF_MAX_WIDTH : canvas_w;
        endfunction

        function int unsigned eff_height();
            return (canvas_h > DEF_MAX_HEIGHT) ? DEF_MAX_HEIGHT : canvas_h;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void note_command(fill_cmd_t c);
            int unsigned        w;
            int unsigned        h;
            int unsigned        xe;
            int unsigned        ye;
            int unsigned        cnt;
            int                 cx;
            int                 cy;
            int                 dx;
            int                 dy;
            bit                 hit;
            logic [PIXEL_W-1:0] color;
            logic [PIXEL_W-1:0] pix;
            fill_result_t       res;
            w = eff_width();
            h = eff_height();
            color = {c.red, c.green, c.blue};
            pix = '0;
            cnt = 0;
            act_count[c.action]++;
            case (c.action)
                ACT_CLEAR:
                begin
                    for (int unsigned i = 0; i < w * h; i++)
                        frame[i] = color;
                    cnt = w * h;
                end
                ACT_RECT, ACT_DISC:
                begin
                    xe = c.x_pos + c.rect_width;
                    ye = c.y_pos + c.rect_height;
                    if (xe > w)
                        xe = w;
                    if (ye > h)
                        ye = h;
                    cx = int'(c.x_pos) + int'(c.rect_width) / 2;
                    cy = int'(c.y_pos) + int'(c.rect_height) / 2;
                    for (int unsigned x = c.x_pos; x < xe; x++)
                    begin
                        for (int unsigned y = c.y_pos; y < ye; y++)
                        begin
                            hit = 1'b1;
                            if (c.action == ACT_DISC)
                            begin
                                dx = int'(x) - cx;
                                dy = int'(y) - cy;
                                hit = (dx * dx + dy * dy) < int'(c.radius_sq);
                            end
                            if (hit)
                            begin
                                frame[y * w + x] = color;
                                cnt++;
                            end
                        end
                    end
                end
                ACT_POINT:
                begin
                    if (c.x_pos < w && c.y_pos < h)
                    begin
                        frame[c.y_pos * w + c.x_pos] = color;
                        cnt = 1;
                    end
                end
                ACT_READ:
                begin
                    if (c.x_pos < w && c.y_pos < h)
                        pix = frame[c.y_pos * w + c.x_pos];
                end
                default:
                begin
                end
            endcase
            pixels_total += cnt;
            res.pixel = pix;
            res.count = COUNT_W'(cnt);
            expected_q.push_back(res);
        endfunction

        function void check_result(logic [PIXEL_W-1:0] pix, logic [COUNT_W-1:0] cnt);
            fill_result_t exp_res;
            if (expected_q.size() == 0)
            begin
                $display("%0t: result with none pending, read_pixel %06h pixels_written %0d",
                         $time, pix, cnt);
                errors++;
                return;
            end
            exp_res = expected_q.pop_front();
            checked++;
            if (pix !== exp_res.pixel)
            begin
                $display("%0t: read_pixel mismatch, expected %06h, actual %06h",
                         $time, exp_res.pixel, pix);
                errors++;
            end
            if (cnt !== exp_res.count)
            begin
                $display("%0t: pixels_written mismatch, expected %0d, actual %0d",
                         $time, exp_res.count, cnt);
                errors++;
            end
        endfunction
    endclass

    logic                clk;
    logic                rst_n     = 1'b0;
    logic                cfg_we    = 1'b0;
    cfg_reg_t            cfg_index = CFG_WIDTH;
    logic [CANVAS_W-1:0] cfg_data  = '0;
    logic                in_valid  = 1'b0;
    logic                in_ready;
    fill_cmd_t           cur_cmd   = '0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    logic [PIXEL_W-1:0]  read_pixel;
    logic [COUNT_W-1:0]  pixels_written;

    fill_scoreboard      sb = new();
    bit                  no_idle = 1'b0;
    int                  hold_req = 0;
    int                  n_settings = 0;

    framebuffer_rect_disc_fill_top u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .action         (cur_cmd.action),
        .x_pos          (cur_cmd.x_pos),
        .y_pos          (cur_cmd.y_pos),
        .rect_width     (cur_cmd.rect_width),
        .rect_height    (cur_cmd.rect_height),
        .red            (cur_cmd.red),
        .green          (cur_cmd.green),
        .blue           (cur_cmd.blue),
        .radius_sq      (cur_cmd.radius_sq),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .read_pixel     (read_pixel),
        .pixels_written (pixels_written)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // note every transaction on both channels
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
                sb.check_result(read_pixel, pixels_written);
            if (in_valid && in_ready)
                sb.note_command(cur_cmd);
        end
    end

    function automatic fill_cmd_t make_cmd(logic [ACTION_W-1:0] act, int x, int y,
                                           int rw, int rh, logic [PIXEL_W-1:0] rgb,
                                           int rsq);
        fill_cmd_t c;
        c.action      = act;
        c.x_pos       = POS_W'(x);
        c.y_pos       = POS_W'(y);
        c.rect_width  = SIZE_W'(rw);
        c.rect_height = SIZE_W'(rh);
        {c.red, c.green, c.blue} = rgb;
        c.radius_sq   = RSQ_W'(rsq);
        return c;
    endfunction

    function automatic fill_cmd_t random_cmd(int unsigned w, int unsigned h);
        fill_cmd_t   c;
        int unsigned pick;
        int unsigned span;
        pick = $urandom_range(0, 99);
        if (pick < 4)
            c.action = ACT_CLEAR;
        else if (pick < 30)
            c.action = ACT_RECT;
        else if (pick < 56)
            c.action = ACT_DISC;
        else if (pick < 76)
            c.action = ACT_POINT;
        else if (pick < 95)
            c.action = ACT_READ;
        else
            c.action = ACTION_W'($urandom_range(ACT_UNUSED_LO, ACT_UNUSED_HI));
        if (w != 0 && $urandom_range(0, 4) != 0)
            c.x_pos = POS_W'($urandom_range(0, w - 1));
        else
            c.x_pos = POS_W'($urandom);
        if (h != 0 && $urandom_range(0, 4) != 0)
            c.y_pos = POS_W'($urandom_range(0, h - 1));
        else
            c.y_pos = POS_W'($urandom);
        span = ($urandom_range(0, 9) == 0) ? MAX_SIZE : 12;
        c.rect_width  = SIZE_W'($urandom_range(0, span));
        c.rect_height = SIZE_W'($urandom_range(0, span));
        c.red   = CHAN_W'($urandom);
        c.green = CHAN_W'($urandom);
        c.blue  = CHAN_W'($urandom);
        if ($urandom_range(0, 4) == 0)
            c.radius_sq = RSQ_W'($urandom);
        else
            c.radius_sq = RSQ_W'($urandom_range(0, (c.rect_width * c.rect_width +
                                                     c.rect_height * c.rect_height) / 2 + 2));
        return c;
    endfunction

    // offer one command after a random gap, return once it is taken
    task automatic send_cmd(fill_cmd_t c);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 4);
        @(negedge clk);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        cur_cmd  <= c;
        in_valid <= 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    // drop valid and hold until every expected result is back
    task automatic drain_results();
        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    task automatic set_canvas_size(logic [CANVAS_W-1:0] w, logic [CANVAS_W-1:0] h);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_WIDTH;
        cfg_data  <= w;
        @(negedge clk);
        cfg_index <= CFG_HEIGHT;
        cfg_data  <= h;
        @(negedge clk);
        cfg_we    <= 1'b0;
        sb.set_canvas(CFG_WIDTH, w);
        sb.set_canvas(CFG_HEIGHT, h);
        n_settings++;
    endtask

    // result side: random stalls, one long hold-off on request
    initial
    begin
        int stall;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_req > 0)
            begin
                stall = hold_req;
                hold_req = 0;
            end
            else
                stall = no_idle ? 0 : $urandom_range(0, 4);
            if (stall != 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ready <= 1'b1;
            do
                @(posedge clk);
            while (!out_valid);
        end
    end

    initial
    begin
        logic [CANVAS_W-1:0] cw;
        logic [CANVAS_W-1:0] ch;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // full canvas at reset size: every store entry gets written first
        send_cmd(make_cmd(ACT_CLEAR, 0, 0, 0, 0, 24'hFFFFFF, 0));
        send_cmd(make_cmd(ACT_READ, 0, 0, 0, 0, 24'h000000, 0));
        send_cmd(make_cmd(ACT_READ, 63, 63, 64, 64, 24'h000000, MAX_RSQ));
        send_cmd(make_cmd(ACT_RECT, 0, 0, 64, 64, 24'h000000, 0));
        send_cmd(make_cmd(ACT_RECT, 63, 63, 64, 64, 24'h123456, 0));
        send_cmd(make_cmd(ACT_RECT, 5, 5, 0, 9, 24'hFFFFFF, 0));
        send_cmd(make_cmd(ACT_DISC, 0, 0, 64, 64, 24'h00FF00, MAX_RSQ));
        send_cmd(make_cmd(ACT_DISC, 3, 3, 9, 9, 24'hFF0000, 0));
        send_cmd(make_cmd(ACT_DISC, 10, 10, 21, 20, 24'h0000FF, 100));
        send_cmd(make_cmd(ACT_POINT, 63, 63, 0, 0, 24'hA5A5A5, 0));
        send_cmd(make_cmd(ACT_READ, 63, 63, 0, 0, 24'h000000, 0));
        send_cmd(make_cmd(ACT_READ, 20, 20, 0, 0, 24'h000000, 0));
        send_cmd(make_cmd(ACT_UNUSED_HI, 7, 7, 7, 7, 24'hFFFFFF, MAX_RSQ));
        send_cmd(make_cmd(ACT_UNUSED_LO, 1, 1, 1, 1, 24'h5A5A5A, 1));
        drain_results();

        // narrow canvas: clipping and off-canvas cases
        set_canvas_size(7'd32, 7'd16);
        send_cmd(make_cmd(ACT_POINT, 40, 5, 0, 0, 24'h111111, 0));
        send_cmd(make_cmd(ACT_POINT, 5, 20, 0, 0, 24'h222222, 0));
        send_cmd(make_cmd(ACT_READ, 40, 2, 0, 0, 24'h000000, 0));
        send_cmd(make_cmd(ACT_RECT, 40, 2, 8, 8, 24'h333333, 0));
        send_cmd(make_cmd(ACT_RECT, 20, 10, 30, 30, 24'h444444, 0));
        send_cmd(make_cmd(ACT_DISC, 24, 8, 16, 16, 24'h555555, 50));
        send_cmd(make_cmd(ACT_READ, 31, 15, 0, 0, 24'h000000, 0));
        send_cmd(make_cmd(ACT_CLEAR, 0, 0, 0, 0, 24'h0F0F0F, 0));
        drain_results();

        // empty and oversized canvas settings
        set_canvas_size(7'd0, 7'd127);
        send_cmd(make_cmd(ACT_CLEAR, 0, 0, 0, 0, 24'h777777, 0));
        send_cmd(make_cmd(ACT_RECT, 0, 0, 64, 64, 24'h777777, 0));
        send_cmd(make_cmd(ACT_READ, 0, 0, 0, 0, 24'h000000, 0));
        drain_results();
        set_canvas_size(7'd127, 7'd0);
        send_cmd(make_cmd(ACT_POINT, 63, 0, 0, 0, 24'h888888, 0));
        drain_results();
        set_canvas_size(7'd1, 7'd1);
        send_cmd(make_cmd(ACT_RECT, 0, 0, 64, 64, 24'h999999, 0));
        send_cmd(make_cmd(ACT_READ, 0, 0, 0, 0, 24'h000000, 0));
        drain_results();

        for (int phase = 0; phase < 6; phase++)
        begin
            case (phase)
                0:       begin cw = 7'd64;  ch = 7'd64;  end
                2:       begin cw = 7'd127; ch = 7'd127; end
                4:       begin cw = 7'd1;   ch = 7'd64;  end
                default:
                begin
                    cw = CANVAS_W'($urandom_range(1, DEF_MAX_WIDTH));
                    ch = CANVAS_W'($urandom_range(1, DEF_MAX_HEIGHT));
                end
            endcase
            set_canvas_size(cw, ch);
            no_idle = (phase == 3);
            if (phase == 2)
                hold_req = 400;
            repeat (19) send_cmd(random_cmd(sb.eff_width(), sb.eff_height()));
            drain_results();
        end
        no_idle = 1'b0;

        repeat (10) @(posedge clk);
        $display("Checked %0d results over %0d canvas settings, %0d pixels predicted.",
                 sb.checked, n_settings, sb.pixels_total);
        $display("Commands: clear %0d, rect %0d, disc %0d, point %0d, read %0d, unused %0d.",
                 sb.act_count[ACT_CLEAR], sb.act_count[ACT_RECT], sb.act_count[ACT_DISC],
                 sb.act_count[ACT_POINT], sb.act_count[ACT_READ],
                 sb.act_count[5] + sb.act_count[6] + sb.act_count[7]);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    initial
    begin
        #30_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule
